@@ hw/rtl/cilm_pkg.sv @@
// Package for the case-insensitive line matcher.
// Shared constants, register indexes and the item and result types.
// No dependencies.
package cilm_pkg;

  // Byte lanes held by the pattern registers
  localparam int unsigned RegBytes = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatLen  = 2'd2;

  // Classified byte passed from the front to the back
  typedef struct packed {
    logic [RegBytes-1:0] eq;
    logic                eol;
  } item_t;

  // Per-line result
  typedef struct packed {
    logic              matched;
    logic [CountW-1:0] length;
  } result_t;

endpackage

@@ hw/rtl/cilm_fifo.sv @@
// Small register queue used between the front and the back and on the
// result side. Depth must be a power of two. Depends on nothing.
module cilm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (Depth > 1) ? wr_ptr_q + PtrW'(1) : '0;
      end
      if (do_pop) begin
        rd_ptr_q <= (Depth > 1) ? rd_ptr_q + PtrW'(1) : '0;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue occupancy above depth");
  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("push did not grow the queue");
  a_pop_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("pop did not shrink the queue");
`endif

endmodule

@@ hw/rtl/cilm_front.sv @@
// Front part of the line matcher: folds case and compares each byte
// against all pattern lanes at once. Depends on cilm_pkg.
module cilm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                ready_o,
  input  logic [7:0]                          text_byte_i,
  input  logic                                end_of_line_i,
  input  logic [cilm_pkg::RegBytes*8-1:0]     pattern_i,
  input  logic [cilm_pkg::LenW-1:0]           eff_len_i,
  output logic                                item_valid_o,
  input  logic                                item_ready_i,
  output cilm_pkg::item_t                     item_o
);

  import cilm_pkg::*;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  logic            valid_q;
  item_t           item_q, item_d;
  logic [7:0]      folded;
  logic            accept;

  assign ready_o      = !valid_q || item_ready_i;
  assign accept       = push_i && ready_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // Compare the folded byte against every active lane
  always_comb begin
    folded     = fold_case(text_byte_i);
    item_d.eol = end_of_line_i;
    for (int i = 0; i < RegBytes; i++) begin
      item_d.eq[i] = (LenW'(i) < eff_len_i) &&
                     (fold_case(pattern_i[i*8 +: 8]) == folded);
    end
  end

  // Hold the classified byte until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

@@ hw/rtl/cilm_back.sv @@
// Back part of the line matcher: shift-and vector, hit flag and byte
// counter; emits one result per line. Depends on cilm_pkg.
module cilm_back #(
  parameter int unsigned VecW = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_empty_i,
  output logic                      item_pop_o,
  input  cilm_pkg::item_t           item_i,
  input  logic [cilm_pkg::LenW-1:0] eff_len_i,
  input  logic                      res_full_i,
  output logic                      res_push_o,
  output cilm_pkg::result_t         res_o
);

  import cilm_pkg::*;

  logic [VecW-1:0]   vec_q, vec_d;
  logic              hit_q, hit_d;
  logic [CountW-1:0] count_q, count_d;
  logic [VecW-1:0]   last_mask;
  logic              take;

  // Drain a byte unless its line result cannot be stored
  assign take       = !item_empty_i && (!item_i.eol || !res_full_i);
  assign item_pop_o = take;
  assign res_push_o = take && item_i.eol;
  assign last_mask  = VecW'(1) << (eff_len_i - LenW'(1));

  // Advance the partial-match vector and the counters
  always_comb begin
    vec_d   = ((vec_q << 1) | VecW'(1)) & item_i.eq[VecW-1:0];
    hit_d   = hit_q || (eff_len_i == '0) || ((vec_d & last_mask) != '0);
    count_d = (count_q == '1) ? count_q : count_q + CountW'(1);
    res_o.matched = hit_d;
    res_o.length  = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q   <= '0;
      hit_q   <= 1'b0;
      count_q <= '0;
    end else if (take) begin
      if (item_i.eol) begin
        vec_q   <= '0;
        hit_q   <= 1'b0;
        count_q <= '0;
      end else begin
        vec_q   <= vec_d;
        hit_q   <= hit_d;
        count_q <= count_d;
      end
    end
  end

`ifndef SYNTH
  a_result_on_eol : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (item_pop_o && item_i.eol && !res_full_i))
    else $error("result pushed without a line end");
  a_clear_after_eol : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.eol) |=> (vec_q == '0 && !hit_q && count_q == '0))
    else $error("line state not cleared after line end");
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !item_i.eol) |=> (count_q != '0))
    else $error("byte count lost inside a line");
`endif

endmodule

@@ hw/rtl/case_insensitive_line_matcher.sv @@
// Case-insensitive line matcher: takes one text byte per cycle while not
// full and, on the byte flagged as the end of a line, queues one result
// (match flag and saturating line length). The sustained rate is one byte per
// clock while neither queue fills; a result passes from its last byte through
// the classify register and the two-entry byte queue, after which the back
// part pushes it into the two-entry result queue.
// Write the pattern registers only while no byte is in flight.
module case_insensitive_line_matcher #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     text_byte_i,
  input  logic                           end_of_line_i,
  input  logic                           pop,
  output logic                           empty,
  output logic                           line_matched_o,
  output logic [15:0]                    line_length_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cilm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cilm_pkg::CfgDataW-1:0]  cfg_data_i
);

  import cilm_pkg::*;

  localparam int unsigned VecW = (PATTERN_MAX < RegBytes) ? PATTERN_MAX : RegBytes;

  logic [CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [LenW-1:0]     pat_len_q;
  logic [LenW-1:0]     eff_len;
  logic                front_ready;
  logic                item_valid, item_full, item_empty, item_pop;
  item_t               front_item, queued_item;
  logic                res_push, res_full;
  result_t             res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign eff_len     = (pat_len_q > LenW'(VecW)) ? LenW'(VecW) : pat_len_q;

  // Decode configuration requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgPatLow:  pat_low_q  <= cfg_data_i;
        CfgPatHigh: pat_high_q <= cfg_data_i;
        CfgPatLen:  pat_len_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign full = !front_ready;

  cilm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .ready_o       (front_ready),
    .text_byte_i   (text_byte_i),
    .end_of_line_i (end_of_line_i),
    .pattern_i     ({pat_high_q, pat_low_q}),
    .eff_len_i     (eff_len),
    .item_valid_o  (item_valid),
    .item_ready_i  (!item_full),
    .item_o        (front_item)
  );

  cilm_fifo #(
    .Width ($bits(item_t)),
    .Depth (2)
  ) u_item_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_valid),
    .full_o  (item_full),
    .data_i  (front_item),
    .pop_i   (item_pop),
    .empty_o (item_empty),
    .data_o  (queued_item)
  );

  cilm_back #(
    .VecW (VecW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .item_i       (queued_item),
    .eff_len_i    (eff_len),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  cilm_fifo #(
    .Width ($bits(result_t)),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign line_matched_o = res_out.matched;
  assign line_length_o  = res_out.length;

endmodule

@@ bench/cilm_line_checker.sv @@
// Checker for the case-insensitive line matcher: mirrors the shift-and search
// on every accepted byte and compares each popped line result in order.
// Depends on cilm_pkg for widths, register indexes and the result type.
module cilm_line_checker #(
  parameter int unsigned PatternMax = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic [7:0]                    text_byte_i,
  input  logic                          end_of_line_i,
  input  logic                          pop_i,
  input  logic                          empty_i,
  input  logic                          line_matched_i,
  input  logic [15:0]                   line_length_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [cilm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cilm_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            errors_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cilm_pkg::*;

  // Mirrored registers and search state
  logic [CfgDataW-1:0] pat_lo;
  logic [CfgDataW-1:0] pat_hi;
  logic [LenW-1:0]     pat_len;
  logic [RegBytes-1:0] match_vec;
  logic                hit;
  logic [CountW-1:0]   count;
  result_t             line_results_q[$];

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  // Pattern length clipped to what the block can hold
  function automatic int unsigned active_len();
    int unsigned n;
    n = 32'(pat_len);
    if (n > PatternMax) n = PatternMax;
    if (n > RegBytes) n = RegBytes;
    return n;
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned i);
    if (i < 8) return pat_lo[(i % 8) * 8 +: 8];
    return pat_hi[(i % 8) * 8 +: 8];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t             want;
    logic [RegBytes-1:0] eq;
    int unsigned         n;
    int unsigned         i;
    int                  err;
    if (!rst_ni) begin
      pat_lo    = '0;
      pat_hi    = '0;
      pat_len   = '0;
      match_vec = '0;
      hit       = 1'b0;
      count     = '0;
      line_results_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      err = 0;

      // Compare a popped result with the oldest expected one
      if (pop_i && !empty_i) begin
        if (line_results_q.size() == 0) begin
          $error("unexpected line result: line_matched %0d line_length %0d",
                 line_matched_i, line_length_i);
          err++;
        end else begin
          want = line_results_q.pop_front();
          if (want.matched !== line_matched_i) begin
            $error("line_matched: expected %0d, got %0d", want.matched, line_matched_i);
            err++;
          end
          if (want.length !== line_length_i) begin
            $error("line_length: expected %0d, got %0d", want.length, line_length_i);
            err++;
          end
        end
      end

      // Advance the search on an accepted byte
      if (push_i && !full_i) begin
        n  = active_len();
        eq = '0;
        for (i = 0; i < RegBytes; i++) begin
          if (i < n && to_lower(pat_byte(i)) == to_lower(text_byte_i)) eq[i] = 1'b1;
        end
        match_vec = ((match_vec << 1) | RegBytes'(1)) & eq;
        if (n == 0 || match_vec[n-1]) hit = 1'b1;
        if (count != '1) count = count + 1'b1;
        if (end_of_line_i) begin
          want.matched = hit;
          want.length  = count;
          line_results_q.push_back(want);
          match_vec = '0;
          hit       = 1'b0;
          count     = '0;
        end
      end

      // Apply a register write; it takes effect from the next byte
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgPatLow:  pat_lo = cfg_data_i;
          CfgPatHigh: pat_hi = cfg_data_i;
          CfgPatLen:  pat_len = cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end

      errors_o  <= errors_o + err;
      pending_o <= line_results_q.size();
    end
  end

endmodule

@@ bench/tb_case_insensitive_line_matcher.sv @@
// Testbench top for the case-insensitive line matcher: drives text lines and
// pattern writes with random gaps and gives the verdict.
// Depends on cilm_pkg, case_insensitive_line_matcher and cilm_line_checker.
module tb_case_insensitive_line_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import cilm_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Index with no register behind it; writes to it are ignored
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongLine  = 60;
  localparam int unsigned Phases    = 8;
  localparam int unsigned PhaseBytes = 160;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [7:0]          text_byte;
  logic                end_of_line;
  logic                pop;
  logic                empty;
  logic                line_matched;
  logic [15:0]         line_length;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  errors;
  int                  pending;

  // Pattern as last written, for building lines around it
  logic [7:0]  pat [RegBytes];
  int unsigned pat_len;
  bit          send_calm;

  case_insensitive_line_matcher #(
    .PATTERN_MAX(16)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte),
    .end_of_line_i (end_of_line),
    .pop           (pop),
    .empty         (empty),
    .line_matched_o(line_matched),
    .line_length_o (line_length),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  cilm_line_checker #(
    .PatternMax(16)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .text_byte_i   (text_byte),
    .end_of_line_i (end_of_line),
    .pop_i         (pop),
    .empty_i       (empty),
    .line_matched_i(line_matched),
    .line_length_i (line_length),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Small alphabet so that patterns recur, with some raw bytes mixed in
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       return 8'h61;
        1:       return 8'h41;
        2:       return 8'h62;
        default: return 8'h42;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
        $urandom_range(0, 1) == 1) return b ^ 8'h20;
    return b;
  endfunction

  function automatic byte_q_t str_bytes(input string s);
    byte_q_t     q;
    int unsigned k;
    q = {};
    for (k = 0; k < s.len(); k++) q.push_back(s[k]);
    return q;
  endfunction

  // Offer one byte and hold it until accepted, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic eol);
    int unsigned gap;
    push        <= 1'b1;
    text_byte   <= b;
    end_of_line <= eol;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    gap = send_calm ? 0 : gap_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_bytes(input byte_q_t q, input bit close);
    int unsigned k;
    for (k = 0; k < q.size(); k++) send_byte(q[k], close && (k == q.size() - 1));
  endtask

  // Stop sending, wait for every outstanding result, then let the pipe drain
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_pattern(input int unsigned len);
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    logic [CfgDataW-1:0] lw;
    int unsigned         k;
    for (k = 0; k < 8; k++) begin
      lo[k*8 +: 8] = pat[k];
      hi[k*8 +: 8] = pat[k+8];
    end
    // Upper bits of the length word carry noise; only the low field counts
    lw = {$urandom, $urandom};
    lw[LenW-1:0] = len[LenW-1:0];
    write_reg(CfgPatLow, lo);
    write_reg(CfgPatHigh, hi);
    write_reg(CfgPatLen, lw);
    pat_len = len;
  endtask

  task automatic load_text_pattern(input string s, input int unsigned len);
    int unsigned k;
    for (k = 0; k < RegBytes; k++) pat[k] = (k < s.len()) ? s[k] : pick_char();
    write_pattern(len);
  endtask

  // Random line: mostly an occurrence (sometimes broken) amid filler, else noise
  task automatic make_line(output byte_q_t q);
    int unsigned n;
    int unsigned cut;
    int unsigned k;
    q = {};
    n = (pat_len > RegBytes) ? RegBytes : pat_len;
    if ($urandom_range(0, 99) < 70) begin
      repeat ($urandom_range(0, 6)) q.push_back(pick_char());
      cut = n;
      if (n != 0 && $urandom_range(0, 4) == 0) cut = $urandom_range(0, n - 1);
      for (k = 0; k < cut; k++) q.push_back(flip_case(pat[k]));
      if (cut != 0 && $urandom_range(0, 9) == 0) q[q.size() - 1] = pick_char();
      repeat ($urandom_range(0, 6)) q.push_back(pick_char());
    end else begin
      repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
    end
    if (q.size() == 0) q.push_back(pick_char());
  endtask

  // Result side: pop with random stalls, with calm stretches now and then
  initial begin
    int unsigned stall_left;
    bit          pop_calm;
    stall_left = 0;
    pop_calm   = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 299) == 0) pop_calm = !pop_calm;
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!pop_calm) stall_left = gap_len();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_case_insensitive_line_matcher: errors");
    $finish;
  end

  // Stimulus
  initial begin
    byte_q_t     txt;
    int unsigned k;
    int unsigned phase;
    int unsigned budget;
    int unsigned r;
    int unsigned len;

    rst_ni      <= 1'b0;
    push        <= 1'b0;
    text_byte   <= '0;
    end_of_line <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    send_calm   = 1'b0;
    pat_len     = 0;
    for (k = 0; k < RegBytes; k++) pat[k] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty pattern after reset: every line matches, a zero byte is ordinary
    send_bytes(str_bytes("a"), 1'b1);
    txt = '{8'h00};
    send_bytes(txt, 1'b1);
    txt = '{8'hFF, 8'h00, 8'h41};
    send_bytes(txt, 1'b1);
    settle();

    // Mixed-case pattern, overlap restart and a zero byte inside a near miss
    load_text_pattern("hElLo", 5);
    send_bytes(str_bytes("say HELLO"), 1'b1);
    send_bytes(str_bytes("hell"), 1'b1);
    send_bytes(str_bytes("helhello"), 1'b1);
    txt = '{8'h48, 8'h45, 8'h4C, 8'h4C, 8'h00, 8'h4F};
    send_bytes(txt, 1'b1);
    settle();

    // Full-width pattern with bytes around the letter ranges
    pat = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h41, 8'h5A,
            8'h61, 8'h7A, 8'h4D, 8'h6E, 8'h80, 8'h7F, 8'h51, 8'h20};
    write_pattern(16);
    txt = '{8'h62, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h61, 8'h7A,
            8'h41, 8'h5A, 8'h6D, 8'h4E, 8'h80, 8'h7F, 8'h71, 8'h20};
    send_bytes(txt, 1'b1);
    txt[1] = 8'h60;
    send_bytes(txt, 1'b1);
    settle();

    // Lengths above capacity clip to the full pattern
    write_pattern(31);
    txt[1] = 8'h40;
    send_bytes(txt, 1'b1);
    settle();
    write_pattern(17);
    send_bytes(txt, 1'b1);
    txt[16] = 8'h21;
    send_bytes(txt, 1'b1);
    settle();
    write_reg(CfgSpare, {$urandom, $urandom});

    // Shorten the pattern in the middle of a line; partial matches carry over
    load_text_pattern("abcd", 4);
    send_bytes(str_bytes("xAb"), 1'b0);
    settle();
    write_reg(CfgPatLen, CfgDataW'(3));
    pat_len = 3;
    send_bytes(str_bytes("C"), 1'b1);
    settle();

    // Long run of filler; the match sits at the very end of the line
    load_text_pattern("zq", 2);
    send_calm = 1'b1;
    for (k = 0; k < LongLine - 2; k++) send_byte(8'h61, 1'b0);
    send_bytes(str_bytes("ZQ"), 1'b1);
    send_bytes(str_bytes("zq"), 1'b1);
    send_calm = 1'b0;
    settle();

    // Random phases, each with a fresh pattern
    for (phase = 0; phase < Phases; phase++) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 0;
      else if (r < 70) len = $urandom_range(1, 4);
      else if (r < 88) len = $urandom_range(5, 16);
      else len = $urandom_range(17, 31);
      if (phase == Phases - 1) len = 16;
      for (k = 0; k < RegBytes; k++) pat[k] = pick_char();
      write_pattern(len);
      send_calm = ($urandom_range(0, 3) == 0);
      budget = PhaseBytes;
      while (budget > 0) begin
        make_line(txt);
        send_bytes(txt, 1'b1);
        budget = (budget > txt.size()) ? budget - txt.size() : 0;
        if ($urandom_range(0, 19) == 0) settle();
      end
      settle();
    end
    send_calm = 1'b0;

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_case_insensitive_line_matcher: clean");
    end else begin
      $display("tb_case_insensitive_line_matcher: errors");
    end
    $finish;
  end

endmodule
